### src/ipow_pkg.sv
`default_nettype none

package ipow_pkg;

  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  typedef enum logic {
    OP_MUL,
    OP_SQR
  } op_t;

  typedef struct packed {
    logic load;
    logic start_mul;
    logic start_sqr;
    logic out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic e_lsb;
    logic e_rest_zero;
    logic mul_done;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/ipow_mul.sv
`default_nettype none

module ipow_mul import ipow_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic                  done,
  output logic      [WIDTH-1:0] p
);

  localparam int DIG   = (WIDTH < 16) ? WIDTH : 16;
  localparam int STEPS = (WIDTH + DIG - 1) / DIG;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [WIDTH-1:0]       a_sh;
  logic [WIDTH-1:0]       b_sh;
  logic [WIDTH+DIG-1:0]   pp;

  assign pp = a_sh * b_sh[DIG-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // one digit of the multiplier operand per cycle, low word kept
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= a;
      b_sh <= b;
      p    <= '0;
    end else if (busy) begin
      a_sh <= a_sh << DIG;
      b_sh <= b_sh >> DIG;
      p    <= p + pp[WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

### src/ipow_dp.sv
`default_nettype none

module ipow_dp import ipow_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic [DATA_W-1:0] base,
  input  wire logic [DATA_W-1:0] exponent,
  output logic      [DATA_W-1:0] power,
  output logic                   zero_base_error
);

  logic [WIDTH-1:0] b_w;
  logic [WIDTH-1:0] e_w;
  logic             b_zero;
  logic             e_zero;
  logic             e_neg;
  logic [WIDTH-1:0] spec_val;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] e;
  logic             special;
  logic             spec_err;
  logic [WIDTH-1:0] spec_res;
  op_t              op;
  logic [WIDTH-1:0] res;
  logic             err;

  logic             mul_done;
  logic [WIDTH-1:0] mul_p;

  assign b_w    = base[WIDTH-1:0];
  assign e_w    = exponent[WIDTH-1:0];
  assign b_zero = (b_w == '0);
  assign e_zero = (e_w == '0);
  assign e_neg  = e_w[WIDTH-1];

  always_comb begin
    spec_val = WIDTH'(1);
    if (b_zero) begin
      spec_val = '0;
    end else if (e_neg) begin
      if (b_w == WIDTH'(1)) begin
        spec_val = WIDTH'(1);
      end else if (&b_w) begin
        spec_val = e_w[0] ? '1 : WIDTH'(1);
      end else begin
        spec_val = '0;
      end
    end
  end

  ipow_mul #(.WIDTH(WIDTH)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_mul | cmd.start_sqr),
    .a     (cmd.start_mul ? acc : sq),
    .b     (sq),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc      <= WIDTH'(1);
      sq       <= b_w;
      e        <= e_w;
      special  <= b_zero | e_zero | e_neg;
      spec_err <= b_zero & (e_zero | e_neg);
      spec_res <= spec_val;
    end else if (mul_done) begin
      if (op == OP_MUL) begin
        acc <= mul_p;
      end else begin
        sq <= mul_p;
        e  <= e >> 1;
      end
    end
    if (cmd.start_mul) begin
      op <= OP_MUL;
    end else if (cmd.start_sqr) begin
      op <= OP_SQR;
    end
    if (cmd.out_write) begin
      res <= special ? spec_res : acc;
      err <= special & spec_err;
    end
  end

  assign stat.special     = special;
  assign stat.e_lsb       = e[0];
  assign stat.e_rest_zero = (e[WIDTH-1:1] == '0);
  assign stat.mul_done    = mul_done;

  assign power           = DATA_W'(signed'(res));
  assign zero_base_error = err;

endmodule

`default_nettype wire

### src/ipow_ctrl.sv
`default_nettype none

module ipow_ctrl import ipow_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.special) begin
          state_next = ST_FINISH;
        end else if (stat.e_lsb) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_SQR;
        end
      end
      ST_MUL: begin
        if (stat.mul_done) begin
          state_next = stat.e_rest_zero ? ST_FINISH : ST_SQR;
        end
      end
      ST_SQR: begin
        if (stat.mul_done) state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.start_mul = !stat.special && stat.e_lsb;
        cmd.start_sqr = !stat.special && !stat.e_lsb;
      end
      ST_MUL: begin
        cmd.start_sqr = stat.mul_done && !stat.e_rest_zero;
      end
      ST_SQR: begin
      end
      ST_FINISH: begin
        cmd.out_write = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_write) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    stat.mul_done |-> (state == ST_MUL || state == ST_SQR))
    else $error("multiplier finished outside a multiply state");

  a_no_instant_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_mul || cmd.start_sqr) |=> !stat.mul_done)
    else $error("multiplier finished one cycle after start");

  a_write_shows_word: assert property (@(posedge clk) disable iff (rst)
    cmd.out_write |=> out_valid)
    else $error("result written but not shown");
`endif

endmodule

`default_nettype wire

### src/integer_power_by_squaring.sv
// channel  signals                       word
// in       in_valid, in_ready            base, exponent
// out      out_valid, out_ready          power, zero_base_error
//
// special cases (zero base, zero or negative exponent) go from the check state straight to finish
// positive exponent: per bit one check, then for a set bit one multiply, then one square, each
// on the shared multiplier, which takes one 16-bit digit (WIDTH bits below 16) per step;
// the top bit skips its square
// rst is synchronous and clears the controller and multiplier state
// a new word is taken while the last result waits; a stalled result holds the
// next one in the controller until out_ready
`default_nettype none

module integer_power_by_squaring import ipow_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] base,
  input  wire logic [DATA_W-1:0] exponent,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] power,
  output logic                   zero_base_error
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ipow_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ipow_dp #(.WIDTH(WIDTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .base            (base),
    .exponent        (exponent),
    .power           (power),
    .zero_base_error (zero_base_error)
  );

endmodule

`default_nettype wire
